// File: src/tss_pkg.sv
// ============================================================================
// tss_pkg: shared types, constants and helpers for the temperature scroller
// Segment codes, range classes, the glyph word passed from front to back,
// and small constant-divisor helpers used for digit extraction.
// ============================================================================
package tss_pkg;

    localparam int FRAMES_DEFAULT        = 8;
    localparam int STRING_LENGTH_DEFAULT = 7;
    localparam int MAX_FRAMES            = 8;
    localparam int GLYPHS                = 5;
    localparam int GIDX_W                = 3;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QPTR_W                = 1;

    localparam logic [7:0] SEG_E      = 8'h79;
    localparam logic [7:0] SEG_C      = 8'h39;
    localparam logic [7:0] SEG_R      = 8'h50;
    localparam logic [7:0] SEG_O      = 8'h5C;
    localparam logic [7:0] SEG_POINT  = 8'h80;
    localparam logic [7:0] SEG_MINUS  = 8'h40;
    localparam logic [7:0] SEG_DEGREE = 8'h63;
    localparam logic [7:0] SEG_BLANK  = 8'h00;

    typedef enum logic [2:0] {
        RANGE_POS_SMALL,
        RANGE_POS_MID,
        RANGE_POS_BIG,
        RANGE_NEG_SMALL,
        RANGE_NEG_MID,
        RANGE_ERROR
    } t_range;

    typedef logic [GLYPHS-1:0][7:0] t_glyphs;

    typedef struct packed {
        logic    valid;
        t_glyphs glyphs;
    } t_glyph_xfer;

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h67;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Remainder by ten for values below 1029, using the 205/2048 reciprocal.
    function automatic logic [3:0] mod10(input logic [9:0] x);
        logic [20:0] prod;
        logic [9:0]  q;
        logic [9:0]  r;
        prod = 21'(x) * 21'd205;
        q    = prod[20:11];
        r    = x - 10'(q * 10'd10);
        return r[3:0];
    endfunction

endpackage

// File: src/tss_front.sv
// ============================================================================
// tss_front: conversion and classification pipeline
// Converts a Celsius sample to Fahrenheit times 80, classifies its range,
// extracts the decimal digits and builds the five-glyph display word.
// ============================================================================
module tss_front
    import tss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [11:0] i_celsius_sixteenths,
    output t_glyph_xfer        o_push,
    input  logic               i_push_ready
);

    logic               r_v1, r_v2, r_v3;
    logic               en1, en2, en3;

    logic signed [15:0] r_f80;
    logic signed [15:0] n_f80;

    t_range             r_range2, n_range2;
    logic [8:0]         r_whole2, n_whole2;
    logic [9:0]         r_tenths2, n_tenths2;
    logic [9:0]         r_hund2, n_hund2;
    logic [14:0]        mag;
    logic [22:0]        whole_prod;
    logic [16:0]        hund_prod;

    t_range             r_range3;
    logic [8:0]         r_whole3;
    logic [4:0]         r_w10;
    logic [4:0]         n_w10;
    logic [1:0]         r_w100;
    logic [1:0]         n_w100;
    logic [9:0]         r_tenths3, r_hund3;
    logic [16:0]        w10_prod;
    logic [13:0]        w100_prod;

    logic [3:0]         d_units, d_tens, d_tenths, d_hund;
    t_glyphs            glyphs;

    assign en3     = !r_v3 || i_push_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage one: F * 80 = 9 * sixteenths + 2560, exact.
    assign n_f80 = ({{4{i_celsius_sixteenths[11]}}, i_celsius_sixteenths} * 16'sd9)
                   + 16'sd2560;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_f80 <= n_f80;
        end
    end

    // Stage two: magnitude, range class and truncated scales.
    always_comb begin
        mag        = (r_f80 < 16'sd0) ? 15'(-r_f80) : 15'(r_f80);
        whole_prod = 23'(mag[14:4]) * 23'd3277;
        n_whole2   = whole_prod[22:14];
        n_tenths2  = mag[12:3];
        hund_prod  = 17'(mag) * 17'd5;
        n_hund2    = hund_prod[11:2];
        if (r_f80 >= 16'sd800 && r_f80 < 16'sd8000) begin
            n_range2 = RANGE_POS_MID;
        end else if (r_f80 >= 16'sd0 && r_f80 < 16'sd800) begin
            n_range2 = RANGE_POS_SMALL;
        end else if (r_f80 > -16'sd800 && r_f80 < 16'sd0) begin
            n_range2 = RANGE_NEG_SMALL;
        end else if (r_f80 > -16'sd8000 && r_f80 <= -16'sd800) begin
            n_range2 = RANGE_NEG_MID;
        end else if (r_f80 >= 16'sd8000) begin
            n_range2 = RANGE_POS_BIG;
        end else begin
            n_range2 = RANGE_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_range2  <= n_range2;
            r_whole2  <= n_whole2;
            r_tenths2 <= n_tenths2;
            r_hund2   <= n_hund2;
        end
    end

    // Stage three: tens and hundreds of the whole part.
    always_comb begin
        w10_prod  = 17'(r_whole2) * 17'd205;
        n_w10     = w10_prod[15:11];
        w100_prod = 14'(r_whole2) * 14'd41;
        n_w100    = w100_prod[13:12];
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_range3  <= r_range2;
            r_whole3  <= r_whole2;
            r_w10     <= n_w10;
            r_w100    <= n_w100;
            r_tenths3 <= r_tenths2;
            r_hund3   <= r_hund2;
        end
    end

    // Digit remainders and glyph selection feed the queue directly.
    always_comb begin
        d_units  = mod10({1'b0, r_whole3});
        d_tens   = mod10({5'b0, r_w10});
        d_tenths = mod10(r_tenths3);
        d_hund   = mod10(r_hund3);
        glyphs[3] = SEG_DEGREE;
        glyphs[4] = SEG_C;
        case (r_range3)
            RANGE_POS_SMALL: begin
                glyphs[0] = SEG_POINT | seg_digit(d_units);
                glyphs[1] = seg_digit(d_tenths);
                glyphs[2] = seg_digit(d_hund);
            end
            RANGE_POS_MID: begin
                glyphs[0] = seg_digit(d_tens);
                glyphs[1] = SEG_POINT | seg_digit(d_units);
                glyphs[2] = seg_digit(d_tenths);
            end
            RANGE_POS_BIG: begin
                glyphs[0] = seg_digit({2'b0, r_w100});
                glyphs[1] = seg_digit(d_tens);
                glyphs[2] = seg_digit(d_units);
            end
            RANGE_NEG_SMALL: begin
                glyphs[0] = SEG_MINUS;
                glyphs[1] = SEG_POINT | seg_digit(d_units);
                glyphs[2] = seg_digit(d_tenths);
            end
            RANGE_NEG_MID: begin
                glyphs[0] = SEG_MINUS;
                glyphs[1] = seg_digit(d_tens);
                glyphs[2] = seg_digit(d_units);
            end
            default: begin
                glyphs[0] = SEG_E;
                glyphs[1] = SEG_R;
                glyphs[2] = SEG_R;
                glyphs[3] = SEG_O;
                glyphs[4] = SEG_R;
            end
        endcase
    end

    assign o_push.valid  = r_v3;
    assign o_push.glyphs = glyphs;

endmodule

// File: src/tss_queue.sv
// ============================================================================
// tss_queue: short glyph-word queue between front and back
// Holds finished display words so the front keeps converting while the
// back is still scrolling an earlier sample.
// ============================================================================
module tss_queue
    import tss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_glyph_xfer i_push,
    output logic        o_push_ready,
    output t_glyph_xfer o_pop,
    input  logic        i_pop_ready
);

    t_glyphs               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]       r_count;
    logic                  do_push, do_pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign do_push      = i_push.valid && o_push_ready;
    assign do_pop       = o_pop.valid && i_pop_ready;

    assign o_pop.valid  = (r_count != '0);
    assign o_pop.glyphs = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.glyphs;
        end
    end

endmodule

// File: src/tss_back.sv
// ============================================================================
// tss_back: scroll frame generator
// Holds the current display word and emits one four-digit frame per cycle
// while i_ready is high, advancing the wrapping scroll start after each frame.
// ============================================================================
module tss_back
    import tss_pkg::*;
#(
    parameter int FRAMES        = FRAMES_DEFAULT,
    parameter int STRING_LENGTH = STRING_LENGTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_glyph_xfer i_pop,
    output logic        o_pop_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_digits [4],
    output logic [2:0]  o_frame_number,
    output logic        o_last_frame
);

    localparam int SW   = $clog2(STRING_LENGTH);
    localparam int EMIT = (FRAMES < MAX_FRAMES) ? FRAMES : MAX_FRAMES;

    logic          r_busy;
    logic [2:0]    r_frame;
    logic [SW-1:0] r_start;
    t_glyphs       r_glyph;
    logic          last, take, load;
    logic [SW:0]   pos [4];
    logic [SW:0]   next_start;

    assign last        = (r_frame == 3'(EMIT - 1));
    assign take        = r_busy && i_ready;
    assign o_pop_ready = !r_busy || (i_ready && last);
    assign load        = i_pop.valid && o_pop_ready;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pos[k] = (SW+1)'(r_start) + (SW+1)'(k);
            if (pos[k] >= (SW+1)'(STRING_LENGTH)) begin
                pos[k] = pos[k] - (SW+1)'(STRING_LENGTH);
            end
            // Glyphs past the fifth are always blank.
            if (pos[k] < (SW+1)'(GLYPHS)) begin
                o_digits[k] = r_glyph[pos[k][GIDX_W-1:0]];
            end else begin
                o_digits[k] = SEG_BLANK;
            end
        end
        next_start = pos[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_frame <= '0;
            r_start <= '0;
        end else begin
            if (take) begin
                r_start <= next_start[SW-1:0];
                r_frame <= last ? 3'd0 : r_frame + 3'd1;
                r_busy  <= !last || i_pop.valid;
            end else if (load) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_glyph <= i_pop.glyphs;
        end
    end

    assign o_valid        = r_busy;
    assign o_frame_number = r_frame;
    assign o_last_frame   = last;

endmodule

// File: src/temperature_seven_segment_scroller.sv
// ============================================================================
// temperature_seven_segment_scroller: Celsius sample to scrolling display
// Top level joining the conversion front, the glyph queue and the scroll
// frame generator.
// ============================================================================
// Usage. The input channel (i_valid, o_ready, i_celsius_sixteenths) takes one
// signed sample in sixteenths of a degree Celsius per transaction. The
// output channel (o_valid, i_ready and the frame fields) delivers
// min(FRAMES, 8) scroll frames for every sample, each frame one transaction
// carrying four segment bytes, its frame number and a last-frame flag.
// Order: when the block is empty, the accepting edge loads the first of
// three conversion stages; the other two stages, the queue write and the
// load of the frame generator follow in that order, and the frame
// generator then offers the first frame of the sample.
// Throughput: the frame generator emits one frame per cycle while i_ready
// is high, so a sample delivers min(FRAMES, 8) frames, eight at the default;
// the next sample's first frame follows its last frame directly when the
// queue already holds it. The conversion front accepts one sample per cycle
// until the two-entry queue and the front's three stages are full.
// Reset clears all valid flags, the queue and the scroll start, which
// otherwise carries over from one sample to the next. When the receiver
// holds i_ready low the current frame stays on the outputs unchanged, and
// the front fills and then drops o_ready.
// ============================================================================
module temperature_seven_segment_scroller
    import tss_pkg::*;
#(
    parameter int FRAMES        = FRAMES_DEFAULT,
    parameter int STRING_LENGTH = STRING_LENGTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [11:0] i_celsius_sixteenths,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_digit_one_segments,
    output logic [7:0]         o_digit_two_segments,
    output logic [7:0]         o_digit_three_segments,
    output logic [7:0]         o_digit_four_segments,
    output logic [2:0]         o_frame_number,
    output logic               o_last_frame
);

    localparam int EMIT = (FRAMES < MAX_FRAMES) ? FRAMES : MAX_FRAMES;

    t_glyph_xfer push, pop;
    logic        push_ready, pop_ready;
    logic [7:0]  digits [4];

    // Front: conversion, range classification and glyph building.
    tss_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_celsius_sixteenths (i_celsius_sixteenths),
        .o_push               (push),
        .i_push_ready         (push_ready)
    );

    // Queue: decouples conversion from scrolling.
    tss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_pop        (pop),
        .i_pop_ready  (pop_ready)
    );

    // Back: one scroll frame per cycle while i_ready is high, from the held display word.
    tss_back #(
        .FRAMES        (FRAMES),
        .STRING_LENGTH (STRING_LENGTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop          (pop),
        .o_pop_ready    (pop_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digits       (digits),
        .o_frame_number (o_frame_number),
        .o_last_frame   (o_last_frame)
    );

    assign o_digit_one_segments   = digits[0];
    assign o_digit_two_segments   = digits[1];
    assign o_digit_three_segments = digits[2];
    assign o_digit_four_segments  = digits[3];

    // The last-frame flag marks exactly the final frame number of a sample.
    a_last_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_frame == (o_frame_number == 3'(EMIT - 1))))
        else $error("last-frame flag disagrees with frame number");

    // Frames of one sample come back to back with consecutive numbers.
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_frame |=>
            o_valid && (o_frame_number == $past(o_frame_number) + 3'd1))
        else $error("scroll frames of a sample are not consecutive");

    // A new sample always starts at frame zero.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_frame |=> (o_frame_number == 3'd0))
        else $error("frame number did not restart after the last frame");

endmodule
